// ===== rtl/core/imu_bias_calibrator_top_defines.svh =====
// assertion macros for the imu bias calibrator rtl
// no dependencies; assertions clock on i_clk and disable on i_rst_n of the including module
`ifndef IMU_BIAS_CALIBRATOR_TOP_DEFINES_SVH
`define IMU_BIAS_CALIBRATOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define IBC_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define IBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IBC_ASSERT(lbl, ante, cons, msg)
`define IBC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ibc_pkg.sv =====
// shared types and constants of the imu bias calibrator
// no dependencies
package ibc_pkg;

    localparam int AXES           = 5;
    localparam int GYRO_AXES      = 3;
    localparam int GYRO_BASE      = 2;
    localparam int SAMPLE_W       = 16;
    localparam int CORR_W         = 17;
    localparam int SUM_W          = 24;
    localparam int MAG_W          = 23;
    localparam int ROUGH_W        = 24;
    localparam int LIMIT_W        = 16;
    localparam int IN_DATA_W      = 80;
    localparam int OUT_DATA_W     = 88;
    localparam int WINDOW_DEFAULT = 200;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd60;
    localparam logic [ROUGH_W-1:0] ROUGH_MAX   = {ROUGH_W{1'b1}};

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [CORR_W-1:0]   t_corr;
    typedef logic [ROUGH_W-1:0]         t_rough;

    // divider status seen by the top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== rtl/core/ibc_bias_div.sv =====
// divides the five window sums by WINDOW, truncated toward zero
// depends on ibc_pkg; reciprocal multiply in three registered stages
module ibc_bias_div #(
    parameter int WINDOW = ibc_pkg::WINDOW_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  ibc_pkg::t_sum        i_sums [ibc_pkg::AXES],
    output ibc_pkg::t_div_status o_status,
    output ibc_pkg::t_sample     o_bias [ibc_pkg::AXES]
);
    import ibc_pkg::*;

    // exact for magnitudes below 2^MAG_W: recip = ceil(2^(MAG_W+L) / WINDOW)
    localparam int L       = $clog2(WINDOW);
    localparam int SHIFT   = MAG_W + L;
    localparam int RECIP_W = MAG_W + 2;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    logic [2:0]        r_v;
    logic [MAG_W-1:0]  r_mag  [AXES];
    logic [AXES-1:0]   r_neg1;
    logic [PROD_W-1:0] r_prod [AXES];
    logic [AXES-1:0]   r_neg2;
    t_sample           r_bias [AXES];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_start};
        end
    end

    // magnitude, product, then shift and sign
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < AXES; i++) begin
            r_mag[i]  <= i_sums[i][SUM_W-1] ? MAG_W'(-i_sums[i]) : MAG_W'(i_sums[i]);
            r_neg1[i] <= i_sums[i][SUM_W-1];
            r_prod[i] <= PROD_W'(r_mag[i]) * PROD_W'(RECIP_V);
            r_neg2[i] <= r_neg1[i];
            r_bias[i] <= r_neg2[i] ? SAMPLE_W'(-CORR_W'(r_prod[i] >> SHIFT))
                                   : SAMPLE_W'(r_prod[i] >> SHIFT);
        end
    end

    assign o_status.busy = |r_v;
    assign o_status.done = r_v[2];
    assign o_bias        = r_bias;

endmodule

// ===== rtl/core/imu_bias_calibrator_top.sv =====
// imu bias calibrator: input is registered into the output register driving m_axis_tvalid;
// one item per cycle sustained while output drains and no divide runs; an output skid register
// keeps input open while a result waits. after a passing window the input stalls while the
// bias divider pipeline runs (once only, calibration is then final). reset is synchronous,
// active low: clears sums, roughness, biases and flags, stillness limit returns to 60.
`include "imu_bias_calibrator_top_defines.svh"
module imu_bias_calibrator_top #(
    parameter int WINDOW = ibc_pkg::WINDOW_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write transaction: stillness limit
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ibc_pkg::LIMIT_W-1:0]         i_cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // accel_x, accel_y, gyro_x, gyro_y, gyro_z (16 bits each, lowest first)
    input  logic [ibc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // accel_x_corrected, accel_y_corrected, gyro_x_corrected, gyro_y_corrected,
    // gyro_z_corrected (17 bits each, lowest first), zero padded
    output logic [ibc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // calibrated
    output logic [0:0]                          m_axis_tuser
);
    import ibc_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);

    logic [LIMIT_W-1:0]    r_limit;
    t_sum                  r_sum  [AXES];
    t_sum                  n_sum  [AXES];
    t_rough                r_rough [GYRO_AXES];
    t_rough                n_rough [GYRO_AXES];
    t_sample               r_prev [GYRO_AXES];
    logic                  r_have_prev;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    t_sample               r_bias [AXES];
    logic                  r_cal_done;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out;
    logic                  r_out_cal;
    logic                  r_skid_valid;
    logic [OUT_DATA_W-1:0] r_skid;
    logic                  r_skid_cal;

    t_sample               smp [AXES];
    logic [OUT_DATA_W-1:0] new_data;
    logic                  accept;
    logic                  pop;
    logic                  win_full;
    logic                  win_fail;
    logic                  div_start;
    t_div_status           div_st;
    t_sample               div_bias [AXES];

    assign o_cfg_ready = 1'b1;

    // stillness limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // unpack samples and form corrected outputs with the biases held so far
    always_comb begin
        new_data = '0;
        for (int i = 0; i < AXES; i++) begin
            smp[i] = t_sample'(s_axis_tdata[i*SAMPLE_W +: SAMPLE_W]);
            new_data[i*CORR_W +: CORR_W] = CORR_W'(t_corr'(smp[i]) - t_corr'(r_bias[i]));
        end
    end

    assign s_axis_tready = !r_skid_valid && !div_st.busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = r_out_valid && m_axis_tready;

    // window accumulation: sums, roughness, count
    always_comb begin
        logic signed [CORR_W-1:0] d;
        logic [SAMPLE_W-1:0]      a;
        logic [ROUGH_W:0]         r;
        for (int i = 0; i < AXES; i++) begin
            n_sum[i] = r_sum[i] + t_sum'(smp[i]);
        end
        win_fail = 1'b0;
        for (int i = 0; i < GYRO_AXES; i++) begin
            d = t_corr'(smp[GYRO_BASE + i]) - t_corr'(r_prev[i]);
            a = d[CORR_W-1] ? SAMPLE_W'(-d) : SAMPLE_W'(d);
            r = {1'b0, r_rough[i]} + (ROUGH_W + 1)'(a);
            if (!r_have_prev) begin
                n_rough[i] = r_rough[i];
            end else if (r[ROUGH_W]) begin
                n_rough[i] = ROUGH_MAX;
            end else begin
                n_rough[i] = r[ROUGH_W-1:0];
            end
            if (n_rough[i] >= t_rough'(r_limit)) begin
                win_fail = 1'b1;
            end
        end
        n_count   = r_count + 1'b1;
        win_full  = (n_count == CNT_W'(WINDOW));
        div_start = accept && !r_cal_done && win_full && !win_fail;
    end

    // calibration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_have_prev <= 1'b0;
            r_cal_done  <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_sum[i]  <= '0;
                r_bias[i] <= '0;
            end
            for (int i = 0; i < GYRO_AXES; i++) begin
                r_rough[i] <= '0;
                r_prev[i]  <= '0;
            end
        end else begin
            if (accept && !r_cal_done) begin
                r_have_prev <= 1'b1;
                for (int i = 0; i < GYRO_AXES; i++) begin
                    r_prev[i] <= smp[GYRO_BASE + i];
                end
                if (win_full) begin
                    r_count <= '0;
                    for (int i = 0; i < AXES; i++) begin
                        r_sum[i] <= '0;
                    end
                    for (int i = 0; i < GYRO_AXES; i++) begin
                        r_rough[i] <= '0;
                    end
                end else begin
                    r_count <= n_count;
                    r_sum   <= n_sum;
                    r_rough <= n_rough;
                end
            end
            if (div_st.done) begin
                r_bias     <= div_bias;
                r_cal_done <= 1'b1;
            end
        end
    end

    // result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out     <= r_skid_valid ? r_skid : new_data;
            r_out_cal <= r_skid_valid ? r_skid_cal : r_cal_done;
        end
        if (accept) begin
            r_skid     <= new_data;
            r_skid_cal <= r_cal_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_out_cal;

    // bias divider
    ibc_bias_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_sums   (n_sum),
        .o_status (div_st),
        .o_bias   (div_bias)
    );

    `IBC_ASSERT(a_no_accept_busy, div_st.busy, !s_axis_tready, "input open during divide")
    `IBC_ASSERT_NXT(a_cal_sticky, r_cal_done, r_cal_done, "calibrated flag dropped")
    `IBC_ASSERT(a_skid_needs_out, r_skid_valid, r_out_valid, "skid full with output empty")
    `IBC_ASSERT_NXT(a_done_sets_cal, div_st.done, r_cal_done && !div_st.busy, "bias not taken")

endmodule
